// File: rtl/core/ce_pkg.sv
// Shared types and constants of the C escape encoder.
package ce_pkg;

  localparam int ESC_BYTES = 4;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_DIGIT0 = 8'h30;
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_BEL    = 8'h07;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LOW_A  = 8'h61;
  localparam logic [7:0] CH_LOW_B  = 8'h62;
  localparam logic [7:0] CH_LOW_F  = 8'h66;
  localparam logic [7:0] CH_LOW_N  = 8'h6E;
  localparam logic [7:0] CH_LOW_R  = 8'h72;
  localparam logic [7:0] CH_LOW_T  = 8'h74;
  localparam logic [7:0] CH_LOW_V  = 8'h76;

  // Register indexes, taken from paddr[2].
  localparam logic REG_OUT_CAPACITY = 1'b0;
  localparam logic REG_STOP_AT_NUL  = 1'b1;

  localparam logic [15:0] CAP_RESET = 16'd256;

  // Escape sequence of one source byte; seq[0] goes out first.
  typedef struct packed {
    logic [ESC_BYTES-1:0][7:0] seq;
    logic [2:0]                len;
    logic                      halt;
  } esc_t;

endpackage

// File: rtl/core/ce_if.sv
// Stream interfaces for source bytes and encoded bytes.
interface ce_raw_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface ce_esc_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        byte_valid;
  logic        run_last;
  logic        string_done;
  logic [15:0] out_length;

  modport source (output valid, output out_byte, output byte_valid, output run_last,
                  output string_done, output out_length, input ready);
  modport sink (input valid, input out_byte, input byte_valid, input run_last,
                input string_done, input out_length, output ready);
endinterface

// File: rtl/core/ce_escape.sv
// Combinational escape lookup for one source byte against the space left.
module ce_escape
  import ce_pkg::*;
#(
  parameter int LENGTH_BITS = 16
) (
  input  logic [7:0]             in_byte,
  input  logic                   stop_at_nul,
  input  logic                   halted,
  input  logic [LENGTH_BITS-1:0] space_left,
  output esc_t                   esc
);

  logic       room2;
  logic       room4;
  logic [7:0] letter;
  logic       is_letter;

  assign room2 = space_left >= LENGTH_BITS'(2);
  assign room4 = space_left >= LENGTH_BITS'(4);

  always_comb begin
    is_letter = 1'b1;
    case (in_byte)
      CH_BEL:  letter = CH_LOW_A;
      CH_BS:   letter = CH_LOW_B;
      CH_FF:   letter = CH_LOW_F;
      CH_LF:   letter = CH_LOW_N;
      CH_CR:   letter = CH_LOW_R;
      CH_TAB:  letter = CH_LOW_T;
      CH_VT:   letter = CH_LOW_V;
      CH_NUL:  letter = CH_DIGIT0;
      default: begin
        letter    = 8'h00;
        is_letter = 1'b0;
      end
    endcase
  end

  always_comb begin
    esc = '0;
    if (!halted && (space_left != '0)) begin
      if (in_byte == CH_BSLASH) begin
        esc.seq[0] = CH_BSLASH;
        esc.seq[1] = CH_BSLASH;
        esc.len    = room2 ? 3'd2 : 3'd1;
      end else if ((in_byte == CH_SQUOTE) || (in_byte == CH_DQUOTE)) begin
        // With one byte of space the quote goes out bare.
        if (room2) begin
          esc.seq[0] = CH_BSLASH;
          esc.seq[1] = in_byte;
          esc.len    = 3'd2;
        end else begin
          esc.seq[0] = in_byte;
          esc.len    = 3'd1;
        end
      end else if (in_byte inside {[8'h20:8'h7E]}) begin
        esc.seq[0] = in_byte;
        esc.len    = 3'd1;
      end else if ((in_byte == CH_NUL) && stop_at_nul) begin
        esc.halt = 1'b1;
      end else if (is_letter) begin
        if (room2) begin
          esc.seq[0] = CH_BSLASH;
          esc.seq[1] = letter;
          esc.len    = 3'd2;
        end else begin
          esc.halt = 1'b1;
        end
      end else if (room4) begin
        esc.seq[0] = CH_BSLASH;
        esc.seq[1] = CH_DIGIT0 | {6'b0, in_byte[7:6]};
        esc.seq[2] = CH_DIGIT0 | {5'b0, in_byte[5:3]};
        esc.seq[3] = CH_DIGIT0 | {5'b0, in_byte[2:0]};
        esc.len    = 3'd4;
      end else begin
        esc.halt = 1'b1;
      end
    end
  end

endmodule

// File: rtl/core/c_escape_encoder.sv
// Top level of the C string escape encoder.
// Each source byte accepted on raw becomes its C escape form on esc, one encoded byte per
// transaction: one byte for printable characters, two for backslash, quotes and the letter
// escapes, four for octal escapes. The per-string state (space left, halted flag, bytes
// emitted) is updated at the moment a source byte is accepted, and the escape is held in a
// sequence register that feeds a single output register, which moves one byte per cycle while
// the receiver is ready; a new source byte is taken in the same cycle the last byte of the
// previous one moves out, so output bytes follow with no gap. A byte that produces nothing
// yields no transaction, unless it is the last of a string, which always yields one closing
// transaction carrying the total length. Capacity and NUL handling are written over the APB
// port; the user is to write them only while the block is idle, which the block itself does
// not enforce. Capacity lives at address 0, stop_at_nul at 4.
module c_escape_encoder
  import ce_pkg::*;
#(
  parameter int LENGTH_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  ce_raw_if.sink        raw,
  ce_esc_if.source      esc,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  // Configuration and per-string state.
  logic [15:0]            out_capacity;
  logic                   stop_at_nul;
  logic [LENGTH_BITS-1:0] space_left;
  logic                   halted;
  logic [LENGTH_BITS-1:0] emitted_count;

  // Sequence register: the escape of the accepted byte awaiting the output register.
  logic                        seq_valid;
  logic [ESC_BYTES-1:0][7:0]   seq_bytes;
  logic [2:0]                  seq_cnt;
  logic                        seq_null;
  logic                        seq_last;
  logic [15:0]                 seq_base;
  logic [1:0]                  seq_idx;

  esc_t                   esc_now;
  logic                   cfg_wr;
  logic [LENGTH_BITS-1:0] new_cap;
  logic [LENGTH_BITS-1:0] len_ext;
  logic                   accept;
  logic                   load;
  logic                   out_free;
  logic                   seq_move;
  logic                   seq_final;

  ce_escape #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_escape (
    .in_byte     (raw.in_byte),
    .stop_at_nul (stop_at_nul),
    .halted      (halted),
    .space_left  (space_left),
    .esc         (esc_now)
  );

  // APB register port; writes complete in the access phase, pready is tied high.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign new_cap = LENGTH_BITS'(pwdata[15:0]);
  assign prdata  = (paddr[2] == REG_OUT_CAPACITY) ? {16'b0, out_capacity}
                                                  : {31'b0, stop_at_nul};

  assign accept  = raw.valid && raw.ready;
  assign len_ext = LENGTH_BITS'(esc_now.len);
  // A byte that produces nothing loads the sequence register only when it closes the string.
  assign load    = accept && ((esc_now.len != 3'd0) || raw.in_last);

  assign out_free  = !esc.valid || esc.ready;
  assign seq_move  = seq_valid && out_free;
  assign seq_final = ({1'b0, seq_idx} == (seq_cnt - 3'd1));
  assign raw.ready = !seq_valid || (seq_move && seq_final);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_capacity  <= CAP_RESET;
      stop_at_nul   <= 1'b1;
      space_left    <= LENGTH_BITS'(CAP_RESET);
      halted        <= 1'b0;
      emitted_count <= '0;
    end else begin
      if (cfg_wr) begin
        if (paddr[2] == REG_OUT_CAPACITY) begin
          out_capacity <= pwdata[15:0];
          // Mid-string, the new capacity is charged with what is already out.
          space_left   <= (new_cap > emitted_count) ? (new_cap - emitted_count) : '0;
        end else begin
          stop_at_nul  <= pwdata[0];
        end
      end
      if (accept) begin
        if (raw.in_last) begin
          space_left    <= LENGTH_BITS'(out_capacity);
          halted        <= 1'b0;
          emitted_count <= '0;
        end else begin
          space_left    <= space_left - len_ext;
          halted        <= halted || esc_now.halt;
          emitted_count <= emitted_count + len_ext;
        end
      end
    end
  end

  // Sequence register control.
  always_ff @(posedge clk) begin
    if (rst) begin
      seq_valid <= 1'b0;
      seq_idx   <= '0;
    end else if (load) begin
      seq_valid <= 1'b1;
      seq_idx   <= '0;
    end else if (seq_move) begin
      seq_valid <= !seq_final;
      seq_idx   <= seq_idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      seq_bytes <= esc_now.seq;
      seq_null  <= (esc_now.len == 3'd0);
      seq_cnt   <= (esc_now.len == 3'd0) ? 3'd1 : esc_now.len;
      seq_last  <= raw.in_last;
      seq_base  <= 16'(emitted_count);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      esc.valid <= 1'b0;
    end else if (seq_move) begin
      esc.valid <= 1'b1;
    end else if (esc.ready) begin
      esc.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (seq_move) begin
      esc.out_byte    <= seq_null ? 8'h00 : seq_bytes[seq_idx];
      esc.byte_valid  <= !seq_null;
      esc.run_last    <= seq_final;
      esc.string_done <= seq_final && seq_last;
      esc.out_length  <= seq_null ? seq_base : (seq_base + 16'(seq_idx) + 16'd1);
    end
  end

  // An empty transaction only ever closes a string.
  a_null_closes: assert property (@(posedge clk) disable iff (rst)
    esc.valid && !esc.byte_valid |-> esc.run_last && esc.string_done)
    else $error("empty transaction that does not close a string");

  // The last byte of a string rearms the per-string state.
  a_rearm: assert property (@(posedge clk) disable iff (rst)
    raw.valid && raw.ready && raw.in_last |=> (emitted_count == '0) && !halted)
    else $error("string state not rearmed after last byte");

  // The sequence index never runs past the escape length.
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    seq_valid |-> ({1'b0, seq_idx} < seq_cnt) && (seq_cnt != 3'd0))
    else $error("sequence index out of range");

  // A new byte is only taken when the held escape is finished or leaving.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    raw.valid && raw.ready && seq_valid |-> seq_move && seq_final)
    else $error("sequence register overwritten");

endmodule

// File: dv/c_escape_encoder_checker.sv
`timescale 1ns / 1ps
// Checker that predicts the C escape encoder's output stream and compares it.
module c_escape_encoder_checker
  import ce_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  ce_raw_if           raw,
  ce_esc_if           esc,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output int          fail_count,
  output int          pending,
  output int          checked_count
);

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        run_last;
    logic        string_done;
    logic [15:0] out_length;
  } enc_beat_t;

  enc_beat_t   expected_beats[$];

  // Mirror of the block's registers and per-string state.
  logic [15:0] capacity;
  logic        stop_nul;
  logic [15:0] space_left;
  logic        halted;
  logic [15:0] emitted;

  int n_fail = 0;
  int n_checked = 0;

  assign fail_count    = n_fail;
  assign checked_count = n_checked;

  task automatic report_mismatch(input string what);
    n_fail++;
    $display("[%0t] ERROR: %s", $time, what);
  endtask

  function automatic logic [7:0] letter_of(input logic [7:0] b);
    case (b)
      CH_BEL:  return CH_LOW_A;
      CH_BS:   return CH_LOW_B;
      CH_FF:   return CH_LOW_F;
      CH_LF:   return CH_LOW_N;
      CH_CR:   return CH_LOW_R;
      CH_TAB:  return CH_LOW_T;
      CH_VT:   return CH_LOW_V;
      CH_NUL:  return CH_DIGIT0;
      default: return 8'h00;
    endcase
  endfunction

  task automatic rearm();
    space_left = capacity;
    halted     = 1'b0;
    emitted    = '0;
  endtask

  // Works out the escape of one source byte and queues its encoded bytes.
  task automatic encode_byte(input logic [7:0] b, input logic last);
    logic [7:0] seq [ESC_BYTES];
    logic [7:0] letter;
    enc_beat_t  beat;
    int         n;
    int         need;
    n = 0;
    if (!halted && space_left != 0) begin
      if (b == CH_BSLASH) begin
        seq[n] = CH_BSLASH;
        n++;
        if (space_left >= 2) begin
          seq[n] = CH_BSLASH;
          n++;
        end
      end else if (b == CH_SQUOTE || b == CH_DQUOTE) begin
        if (space_left >= 2) begin
          seq[n] = CH_BSLASH;
          n++;
        end
        seq[n] = b;
        n++;
      end else if (b >= 8'h20 && b <= 8'h7E) begin
        seq[n] = b;
        n++;
      end else if (b == CH_NUL && stop_nul) begin
        halted = 1'b1;
      end else begin
        letter = letter_of(b);
        need   = (letter != 8'h00) ? 2 : 4;
        if (need > space_left) begin
          halted = 1'b1;
        end else begin
          seq[0] = CH_BSLASH;
          if (letter != 8'h00) begin
            seq[1] = letter;
          end else begin
            seq[1] = CH_DIGIT0 + {6'd0, b[7:6]};
            seq[2] = CH_DIGIT0 + {5'd0, b[5:3]};
            seq[3] = CH_DIGIT0 + {5'd0, b[2:0]};
          end
          n = need;
        end
      end
    end

    for (int k = 0; k < n; k++) begin
      emitted           = emitted + 16'd1;
      space_left        = space_left - 16'd1;
      beat.out_byte     = seq[k];
      beat.byte_valid   = 1'b1;
      beat.run_last     = (k == n - 1);
      beat.string_done  = (k == n - 1) && last;
      beat.out_length   = emitted;
      expected_beats.push_back(beat);
    end

    // A last byte that emits nothing still closes the string with one beat.
    if (n == 0 && last) begin
      beat.out_byte    = 8'h00;
      beat.byte_valid  = 1'b0;
      beat.run_last    = 1'b1;
      beat.string_done = 1'b1;
      beat.out_length  = emitted;
      expected_beats.push_back(beat);
    end

    if (last) begin
      rearm();
    end
  endtask

  task automatic check_beat();
    enc_beat_t want;
    if (expected_beats.size() == 0) begin
      report_mismatch($sformatf("unexpected output transaction, byte %02h length %0d",
                                esc.out_byte, esc.out_length));
    end else begin
      want = expected_beats.pop_front();
      n_checked++;
      if (esc.out_byte !== want.out_byte)
        report_mismatch($sformatf("out_byte %02h, expected %02h",
                                  esc.out_byte, want.out_byte));
      if (esc.byte_valid !== want.byte_valid)
        report_mismatch($sformatf("byte_valid %0b, expected %0b",
                                  esc.byte_valid, want.byte_valid));
      if (esc.run_last !== want.run_last)
        report_mismatch($sformatf("run_last %0b, expected %0b",
                                  esc.run_last, want.run_last));
      if (esc.string_done !== want.string_done)
        report_mismatch($sformatf("string_done %0b, expected %0b",
                                  esc.string_done, want.string_done));
      if (esc.out_length !== want.out_length)
        report_mismatch($sformatf("out_length %0d, expected %0d",
                                  esc.out_length, want.out_length));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      capacity = CAP_RESET;
      stop_nul = 1'b1;
      rearm();
      expected_beats.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_OUT_CAPACITY) begin
          capacity   = pwdata[15:0];
          space_left = (capacity > emitted) ? capacity - emitted : 16'd0;
        end else begin
          stop_nul = pwdata[0];
        end
      end
      if (raw.valid && raw.ready) begin
        encode_byte(raw.in_byte, raw.in_last);
      end
      if (esc.valid && esc.ready) begin
        check_beat();
      end
    end
    pending <= expected_beats.size();
  end

endmodule

// File: dv/c_escape_encoder_tb.sv
`timescale 1ns / 1ps
// Testbench top: drives source strings and register writes into the C escape encoder.
module c_escape_encoder_tb
  import ce_pkg::*;
;

  // Cycles with no transaction on either stream and no register write before giving up.
  // The longest legal quiet stretch is a receiver stall at 67 percent idling plus the
  // settling pause around register writes, so this is far above any correct run.
  localparam int WATCHDOG_LIMIT = 2000;

  // Cycles let pass after the last expected transaction before touching registers. A byte
  // that emits nothing still has to be accepted by the block; this covers it with margin.
  localparam int SETTLE_CYCLES = 8;

  localparam int SEGMENTS      = 6;
  localparam int SEGMENT_ITEMS = 28;

  localparam logic [7:0] EVERY_CLASS [15] = '{
    8'h20, 8'h7E, CH_BSLASH, CH_SQUOTE, CH_DQUOTE, CH_BEL, CH_BS, CH_TAB,
    CH_LF, CH_VT, CH_FF, CH_CR, 8'h01, 8'h80, 8'hFF
  };

  localparam logic [7:0] LETTER_CTRL [7] = '{
    CH_BEL, CH_BS, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  ce_raw_if raw_if ();
  ce_esc_if esc_if ();

  int fail_count;
  int pending;
  int checked_count;

  // Percent of cycles in which the sender holds back and the receiver stalls.
  int src_idle_pct = 13;
  int snk_idle_pct = 67;

  int bytes_sent = 0;
  int strings_sent = 0;
  int settings_used = 1;
  int stall_cycles = 0;

  always #5 clk = ~clk;

  c_escape_encoder u_dut (
    .clk     (clk),
    .rst     (rst),
    .raw     (raw_if),
    .esc     (esc_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  c_escape_encoder_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .raw           (raw_if),
    .esc           (esc_if),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .fail_count    (fail_count),
    .pending       (pending),
    .checked_count (checked_count)
  );

  // The receiver decides afresh every cycle whether it takes an encoded byte.
  always @(posedge clk) begin
    esc_if.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  // Any transaction or register access restarts the count of quiet cycles.
  always @(posedge clk) begin
    if ((raw_if.valid && raw_if.ready) || (esc_if.valid && esc_if.ready) ||
        (psel && penable)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired after %0d quiet cycles, %0d transactions still expected",
               stall_cycles, pending);
      $display("Mismatches found");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Offers one source byte, possibly after a few idle cycles, and returns at the edge
  // where the block takes it. Valid stays high on return so back-to-back bytes need no gap.
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      raw_if.valid <= 1'b0;
      @(posedge clk);
    end
    raw_if.valid   <= 1'b1;
    raw_if.in_byte <= b;
    raw_if.in_last <= last;
    @(posedge clk);
    while (!raw_if.ready) @(posedge clk);
    bytes_sent++;
    if (last) strings_sent++;
  endtask

  // Drops valid and waits until every predicted transaction has come out and the block
  // has had time to finish any byte that produced nothing.
  task automatic settle_encoder();
    raw_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One APB write: a setup phase, an access phase, then the bus is released.
  task automatic write_register(input logic idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    settings_used++;
  endtask

  // Source bytes are weighted toward the classes that behave differently: plain
  // printable text, characters that need a backslash, letter escapes and NUL. The
  // rest are fully random so every bit of the byte toggles.
  function automatic logic [7:0] pick_source_byte();
    int sel;
    sel = $urandom_range(99);
    if (sel < 40) return 8'($urandom_range(126, 32));
    if (sel < 55) begin
      case ($urandom_range(2))
        0:       return CH_BSLASH;
        1:       return CH_SQUOTE;
        default: return CH_DQUOTE;
      endcase
    end
    if (sel < 70) return LETTER_CTRL[$urandom_range(6)];
    if (sel < 78) return CH_NUL;
    return 8'($urandom_range(255));
  endfunction

  // A string is mostly short, now and then long enough to run the space out.
  task automatic send_random_string();
    int len;
    len = ($urandom_range(9) == 0) ? $urandom_range(40, 10) : $urandom_range(8, 1);
    for (int i = 0; i < len; i++) begin
      send_byte(pick_source_byte(), i == len - 1);
    end
  endtask

  initial begin
    logic [15:0] seg_capacity [SEGMENTS];
    logic        seg_stop_nul [SEGMENTS];
    int          seg_start;

    raw_if.valid   <= 1'b0;
    raw_if.in_byte <= 8'h00;
    raw_if.in_last <= 1'b0;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, run with the reset settings first: one string that walks through
    // every class of byte but NUL, ending on the highest byte value with the last flag set.
    for (int i = 0; i < 15; i++) begin
      send_byte(EVERY_CLASS[i], i == 14);
    end
    // NUL in stop mode halts the string; the following byte is ignored and the last
    // flag then yields a closing transaction with no byte.
    send_byte(CH_NUL, 1'b0);
    send_byte(8'h41, 1'b1);

    // A backslash with room for one byte only goes out bare.
    settle_encoder();
    write_register(REG_OUT_CAPACITY, 32'd1);
    send_byte(CH_BSLASH, 1'b1);

    // A quote that lands on the last free byte also goes out bare.
    settle_encoder();
    write_register(REG_OUT_CAPACITY, 32'd2);
    send_byte(8'h41, 1'b0);
    send_byte(CH_DQUOTE, 1'b1);

    // An octal escape that needs four bytes with only three free halts the string.
    settle_encoder();
    write_register(REG_OUT_CAPACITY, 32'd3);
    send_byte(8'h7F, 1'b1);

    // Zero capacity: nothing is ever encoded, only the closing transaction appears.
    settle_encoder();
    write_register(REG_OUT_CAPACITY, 32'd0);
    send_byte(8'h41, 1'b1);

    // With NUL stop disabled a NUL byte is encoded as backslash zero.
    settle_encoder();
    write_register(REG_OUT_CAPACITY, 32'd256);
    write_register(REG_STOP_AT_NUL, 32'd0);
    send_byte(CH_NUL, 1'b1);

    // Capacity rewritten in the middle of a string: after two bytes a capacity of three
    // leaves one byte, so the quote goes out bare; a capacity of one then saturates the
    // remaining space at zero and the last byte is dropped.
    settle_encoder();
    send_byte(8'h41, 1'b0);
    send_byte(8'h42, 1'b0);
    settle_encoder();
    write_register(REG_OUT_CAPACITY, 32'd3);
    send_byte(CH_SQUOTE, 1'b0);
    settle_encoder();
    write_register(REG_OUT_CAPACITY, 32'd1);
    send_byte(8'h43, 1'b1);

    // Random part. Each idle pattern gets two register settings, and the capacity
    // extremes are among them. Most settings are small so strings hit the space limit.
    seg_capacity = '{16'd12, 16'hFFFF, 16'd3, 16'd40, 16'd0, 16'($urandom_range(64, 1))};
    seg_stop_nul = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'($urandom_range(1))};

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      settle_encoder();
      case (seg / 2)
        0: begin
          src_idle_pct = 13;
          snk_idle_pct = 67;
        end
        1: begin
          src_idle_pct = 67;
          snk_idle_pct = 13;
        end
        default: begin
          src_idle_pct = 0;
          snk_idle_pct = 0;
        end
      endcase
      write_register(REG_OUT_CAPACITY, {16'd0, seg_capacity[seg]});
      write_register(REG_STOP_AT_NUL, {31'd0, seg_stop_nul[seg]});
      seg_start = bytes_sent;
      while (bytes_sent - seg_start < SEGMENT_ITEMS) begin
        send_random_string();
      end
    end

    // Let everything drain, then give the verdict.
    settle_encoder();
    repeat (20) @(posedge clk);

    $display("Sent %0d source bytes in %0d strings; %0d encoded transactions were checked.",
             bytes_sent, strings_sent, checked_count);
    $display("Covered %0d register settings, capacity 0 to 65535, both NUL modes, %s",
             settings_used, "three idle patterns.");
    if (pending != 0) begin
      $display("ERROR: %0d expected transactions never arrived", pending);
    end
    if (fail_count == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: c_escape_encoder.f
rtl/core/ce_pkg.sv
rtl/core/ce_if.sv
rtl/core/ce_escape.sv
rtl/core/c_escape_encoder.sv
dv/c_escape_encoder_checker.sv
dv/c_escape_encoder_tb.sv
